[rtl/core/crb_pkg.sv]
// shared types and constants of the coalescing response buffer
package crb_pkg;

	localparam int EntryCount = 8;
	localparam int WriteBits  = 8;
	localparam int ReasonBits = 32;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_OUT
	} crb_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} crb_cmd_t;

endpackage

[rtl/core/crb_ctrl.sv]
// controller state machine: input capture, execute step and result hand-off
module crb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output crb_pkg::crb_cmd_t cmd
);
	import crb_pkg::*;

	crb_state_t state_q;
	crb_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/crb_datapath.sv]
// datapath: pending entries, generic slot, coalescing search and result register
module crb_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  crb_pkg::crb_cmd_t                     cmd,
	input  logic                                  op,
	input  logic [crb_pkg::WriteBits-1:0]         write_mask,
	input  logic signed [crb_pkg::ReasonBits-1:0] write_reason,
	output logic [crb_pkg::WriteBits-1:0]         read_mask,
	output logic signed [crb_pkg::ReasonBits-1:0] read_reason,
	output logic                                  now_empty
);
	import crb_pkg::*;

	logic                                   op_q;
	logic [WriteBits-1:0]                   wmask_q;
	logic [ReasonBits-1:0]                  wreason_q;
	logic [EntryCount-1:0]                  entry_valid_q;
	logic [EntryCount-1:0][ReasonBits-1:0]  entry_reason_q;
	logic                                   gen_valid_q;
	logic [ReasonBits-1:0]                  gen_reason_q;
	logic                                   empty_q;
	logic [WriteBits-1:0]                   read_mask_q;
	logic [ReasonBits-1:0]                  read_reason_q;
	logic                                   now_empty_q;

	logic [ReasonBits-1:0]                  first_reason;
	logic [EntryCount-1:0]                  hit;
	logic [EntryCount-1:0]                  wr_sel;
	logic [WriteBits-1:0]                   gather;
	logic [WriteBits-1:0]                   valid_low;

	// lowest valid entry and all entries sharing its reason
	always_comb begin
		first_reason = '0;
		for (int k = EntryCount - 1; k >= 0; k--) begin
			if (entry_valid_q[k]) begin
				first_reason = entry_reason_q[k];
			end
		end
		for (int k = 0; k < EntryCount; k++) begin
			hit[k] = entry_valid_q[k] && (entry_reason_q[k] == first_reason);
		end
	end

	// write selects and low result bits
	always_comb begin
		for (int k = 0; k < EntryCount; k++) begin
			if (k < WriteBits) begin
				wr_sel[k] = wmask_q[k];
			end else begin
				wr_sel[k] = 1'b0;
			end
		end
		for (int k = 0; k < WriteBits; k++) begin
			if (k < EntryCount) begin
				gather[k]    = hit[k];
				valid_low[k] = entry_valid_q[k];
			end else begin
				gather[k]    = 1'b0;
				valid_low[k] = 1'b0;
			end
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op;
			wmask_q   <= write_mask;
			wreason_q <= $unsigned(write_reason);
		end
	end

	// entry reasons and generic reason
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_WRITE) begin
			if (wmask_q == '0) begin
				gen_reason_q <= wreason_q;
			end else begin
				for (int k = 0; k < EntryCount; k++) begin
					if (wr_sel[k]) begin
						entry_reason_q[k] <= wreason_q;
					end
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == OP_WRITE) begin
				read_mask_q   <= '0;
				read_reason_q <= '0;
			end else if (gen_valid_q) begin
				read_mask_q   <= '0;
				read_reason_q <= gen_reason_q;
			end else begin
				read_mask_q   <= gather;
				read_reason_q <= first_reason;
			end
		end
	end

	// control state of the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			gen_valid_q   <= 1'b0;
			empty_q       <= 1'b1;
			now_empty_q   <= 1'b1;
		end else if (cmd.exec) begin
			if (op_q == OP_WRITE) begin
				if (wmask_q == '0) begin
					gen_valid_q <= 1'b1;
				end else begin
					entry_valid_q <= entry_valid_q | wr_sel;
				end
				empty_q     <= 1'b0;
				now_empty_q <= 1'b0;
			end else if (gen_valid_q) begin
				gen_valid_q <= 1'b0;
				empty_q     <= ~|entry_valid_q;
				now_empty_q <= ~|entry_valid_q;
			end else begin
				entry_valid_q <= entry_valid_q & ~hit;
				empty_q       <= ~|(entry_valid_q & ~hit);
				now_empty_q   <= ~|(entry_valid_q & ~hit);
			end
		end
	end

	assign read_mask   = read_mask_q;
	assign read_reason = $signed(read_reason_q);
	assign now_empty   = now_empty_q;

`ifndef ASSERT_OFF
	a_gen_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && op_q == OP_READ && gen_valid_q |=> !gen_valid_q && read_mask_q == '0)
		else $error("generic slot not cleared by read");

	a_write_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && op_q == OP_WRITE |=> !now_empty_q && !empty_q)
		else $error("buffer empty after write");

	a_read_bits_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && op_q == OP_READ |=> (read_mask_q & valid_low) == '0)
		else $error("coalesced entry still pending");

	a_empty_matches: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && op_q == OP_READ |=> empty_q == !(gen_valid_q || (|entry_valid_q)))
		else $error("empty flag out of step with pending entries");
`endif

endmodule

[rtl/core/coalescing_response_buffer_core.sv]
// coalescing response buffer top level: controller and datapath
// a result is valid in ST_OUT, reached through the ST_EXEC step after its transaction is accepted
// a new transaction is accepted only in ST_IDLE, after the last result has left ST_OUT; out_stall holds it there
// the execute step, state ST_EXEC, holds the entry search, reason compares and state update
// reset: arst_n clears all entries and the generic slot, empty flag set, channels idle
module coalescing_response_buffer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  op,
	input  logic [crb_pkg::WriteBits-1:0]         write_mask,
	input  logic signed [crb_pkg::ReasonBits-1:0] write_reason,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [crb_pkg::WriteBits-1:0]         read_mask,
	output logic signed [crb_pkg::ReasonBits-1:0] read_reason,
	output logic                                  now_empty
);
	import crb_pkg::*;

	crb_cmd_t cmd;

	crb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	crb_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (op),
		.write_mask   (write_mask),
		.write_reason (write_reason),
		.read_mask    (read_mask),
		.read_reason  (read_reason),
		.now_empty    (now_empty)
	);

endmodule
